// ----- rtl/fvc_pkg.sv -----
// Shared types, widths and codes for the frustum volume cull pipeline.
package fvc_pkg;

    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NUM_PLANES       = 6;
    localparam int PLANE_FIELD_BITS = 16;
    localparam int PLANE_BITS       = 4 * PLANE_FIELD_BITS;
    localparam int CFG_INDEX_BITS   = 3;
    localparam int EXTENT_BITS      = COORD_BITS - 1;

    localparam int S_TDATA_FIELD_BITS = 6 * COORD_BITS + EXTENT_BITS;
    localparam int S_TDATA_BITS       = ((S_TDATA_FIELD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS       = 8;
    localparam int S_TUSER_BITS       = 2;

    localparam int PROD_BITS = PLANE_FIELD_BITS + COORD_BITS + 1;
    localparam int BIAS_BITS = ((PLANE_FIELD_BITS > COORD_BITS) ? PLANE_FIELD_BITS : COORD_BITS)
                               + NORMAL_FRAC_BITS + 1;
    localparam int SUM_BITS  = ((PROD_BITS > BIAS_BITS) ? PROD_BITS : BIAS_BITS) + 2;

    typedef enum logic [1:0] {
        OP_POINT  = 2'd0,
        OP_SPHERE = 2'd1,
        OP_BOX    = 2'd2,
        OP_CUBE   = 2'd3
    } op_t;

    typedef logic signed [COORD_BITS:0]           coord_t;
    typedef logic        [EXTENT_BITS-1:0]        extent_t;
    typedef logic signed [PLANE_FIELD_BITS-1:0]   pfield_t;
    typedef logic        [PLANE_BITS-1:0]         plane_t;
    typedef logic signed [PROD_BITS-1:0]          prod_t;
    typedef logic signed [SUM_BITS-1:0]           sum_t;

    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
    } lane_en_t;

endpackage

// ----- rtl/fvc_plane_regs.sv -----
// Configuration register file holding the six frustum planes.
module fvc_plane_regs
    import fvc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [PLANE_BITS-1:0]     cfg_data,
    output plane_t                    planes [NUM_PLANES]
);

    plane_t plane_reg [NUM_PLANES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                if (cfg_index == CFG_INDEX_BITS'(i))
                begin
                    plane_reg[i] <= cfg_data;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            planes[i] = plane_reg[i];
        end
    end

endmodule

// ----- rtl/fvc_front.sv -----
// Input stage: unpacks a request and forms the low and high corner coordinates.
module fvc_front
    import fvc_pkg::*;
(
    input  logic                    clk,
    input  logic                    load,
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    input  logic [S_TUSER_BITS-1:0] s_tuser,
    output op_t                     op,
    output coord_t                  lo [3],
    output coord_t                  hi [3],
    output extent_t                 ext
);

    op_t     op_reg;
    coord_t  lo_reg [3];
    coord_t  hi_reg [3];
    extent_t ext_reg;

    op_t     op_next;
    coord_t  lo_next [3];
    coord_t  hi_next [3];
    extent_t ext_next;

    always_comb
    begin
        logic signed [COORD_BITS-1:0] a_raw;
        logic signed [COORD_BITS-1:0] b_raw;
        op_next  = op_t'(s_tuser);
        ext_next = s_tdata[6*COORD_BITS +: EXTENT_BITS];
        for (int k = 0; k < 3; k++)
        begin
            a_raw      = s_tdata[k*COORD_BITS +: COORD_BITS];
            b_raw      = s_tdata[(k+3)*COORD_BITS +: COORD_BITS];
            lo_next[k] = coord_t'(a_raw);
            if (op_next == OP_CUBE)
            begin
                hi_next[k] = coord_t'(a_raw) + coord_t'({2'b00, ext_next});
            end
            else
            begin
                hi_next[k] = coord_t'(b_raw);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg  <= op_next;
            ext_reg <= ext_next;
            for (int k = 0; k < 3; k++)
            begin
                lo_reg[k] <= lo_next[k];
                hi_reg[k] <= hi_next[k];
            end
        end
    end

    assign op  = op_reg;
    assign ext = ext_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lo[k] = lo_reg[k];
            hi[k] = hi_reg[k];
        end
    end

endmodule

// ----- rtl/fvc_lane.sv -----
// Per-plane lane: corner selection, products and signed distance sum.
module fvc_lane
    import fvc_pkg::*;
(
    input  logic     clk,
    input  lane_en_t en,
    input  plane_t   plane,
    input  op_t      op,
    input  coord_t   lo [3],
    input  coord_t   hi [3],
    input  extent_t  ext,
    output logic     front
);

    pfield_t n [3];
    pfield_t d;

    coord_t coord_reg  [3];
    coord_t coord_next [3];
    sum_t   bias2_reg;
    sum_t   bias2_next;

    prod_t  prod_reg  [3];
    prod_t  prod_next [3];
    sum_t   bias3_reg;

    sum_t   sum_reg;
    sum_t   sum_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            n[k] = plane[k*PLANE_FIELD_BITS +: PLANE_FIELD_BITS];
        end
        d = plane[3*PLANE_FIELD_BITS +: PLANE_FIELD_BITS];
    end

    // For boxes and cubes the corner farthest along the normal is picked axis by axis,
    // so one distance stands for all eight corners.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (!op[1])
            begin
                coord_next[k] = lo[k];
            end
            else if (n[k][PLANE_FIELD_BITS-1])
            begin
                coord_next[k] = (lo[k] < hi[k]) ? lo[k] : hi[k];
            end
            else
            begin
                coord_next[k] = (lo[k] < hi[k]) ? hi[k] : lo[k];
            end
        end
        bias2_next = sum_t'(d) <<< NORMAL_FRAC_BITS;
        if (op == OP_SPHERE)
        begin
            bias2_next = bias2_next + (sum_t'({1'b0, ext}) <<< NORMAL_FRAC_BITS);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_next[k] = prod_t'(n[k]) * prod_t'(coord_reg[k]);
        end
        sum_next = sum_t'(prod_reg[0]) + sum_t'(prod_reg[1]) + sum_t'(prod_reg[2]) + bias3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.ld2)
        begin
            bias2_reg <= bias2_next;
            for (int k = 0; k < 3; k++)
            begin
                coord_reg[k] <= coord_next[k];
            end
        end
        if (en.ld3)
        begin
            bias3_reg <= bias2_reg;
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
        if (en.ld4)
        begin
            sum_reg <= sum_next;
        end
    end

    assign front = !sum_reg[SUM_BITS-1] && (sum_reg != '0);

endmodule

// ----- rtl/frustum_volume_cull.sv -----
// Frustum volume cull: tests a point, sphere, box or cube against six planes.
// An accepted request runs through the five register stages to the result on m_tdata.
// Throughput is one request per cycle unless m_tready stalls the output.
// Stages, each with its own valid bit: input, corner select, multiply, sum, compare.
// Reset clears all valid bits and sets the six plane registers to zero.
module frustum_volume_cull
    import fvc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [S_TDATA_BITS-1:0]   s_tdata,   // x0, y0, z0, x1, y1, z1, extent, zero pad
    input  logic [S_TUSER_BITS-1:0]   s_tuser,   // operation
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [M_TDATA_BITS-1:0]   m_tdata,   // visible, zero pad
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [PLANE_BITS-1:0]     cfg_data
);

    plane_t   planes [NUM_PLANES];
    op_t      op1;
    coord_t   lo1 [3];
    coord_t   hi1 [3];
    extent_t  ext1;
    logic     front [NUM_PLANES];
    lane_en_t lane_en;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic vis_reg;
    logic vis_next;
    logic adv1, adv2, adv3, adv4, adv5;

    assign adv5 = !v5_reg || m_tready;
    assign adv4 = !v4_reg || adv5;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign lane_en.ld2 = adv2;
    assign lane_en.ld3 = adv3;
    assign lane_en.ld4 = adv4;

    assign s_tready = adv1;

    fvc_plane_regs u_planes (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    fvc_front u_front (
        .clk     (clk),
        .load    (adv1),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .op      (op1),
        .lo      (lo1),
        .hi      (hi1),
        .ext     (ext1)
    );

    for (genvar i = 0; i < NUM_PLANES; i++)
    begin : g_lane
        fvc_lane u_lane (
            .clk   (clk),
            .en    (lane_en),
            .plane (planes[i]),
            .op    (op1),
            .lo    (lo1),
            .hi    (hi1),
            .ext   (ext1),
            .front (front[i])
        );
    end

    always_comb
    begin
        vis_next = 1'b1;
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            vis_next = vis_next && front[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= s_tvalid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
            if (adv5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv5)
        begin
            vis_reg <= vis_next;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = {{(M_TDATA_BITS-1){1'b0}}, vis_reg};

endmodule

// ----- verif/fvc_checker.sv -----
// Checker for the frustum volume cull block: predicts each visibility result and compares it.
module fvc_checker
    import fvc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [S_TDATA_BITS-1:0]   s_tdata,
    input  logic [S_TUSER_BITS-1:0]   s_tuser,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [M_TDATA_BITS-1:0]   m_tdata,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [PLANE_BITS-1:0]     cfg_data,
    output int                        fail_count,
    output int                        pending_count,
    output int                        result_count,
    output int                        visible_count
);

    typedef struct {
        logic visible;
        op_t  op;
        int   tag;
    } cull_verdict_t;

    logic [PLANE_BITS-1:0] plane_regs [NUM_PLANES];
    cull_verdict_t         verdict_q [$];
    int                    query_count;

    function automatic longint coord_at(input logic [S_TDATA_BITS-1:0] data, input int idx);
        logic signed [COORD_BITS-1:0] raw;
        raw = data[idx*COORD_BITS +: COORD_BITS];
        return longint'(raw);
    endfunction

    function automatic longint plane_distance(input logic [PLANE_BITS-1:0] plane,
                                              input longint x, input longint y,
                                              input longint z);
        logic signed [PLANE_FIELD_BITS-1:0] nx;
        logic signed [PLANE_FIELD_BITS-1:0] ny;
        logic signed [PLANE_FIELD_BITS-1:0] nz;
        logic signed [PLANE_FIELD_BITS-1:0] d;
        nx = plane[0 +: PLANE_FIELD_BITS];
        ny = plane[PLANE_FIELD_BITS +: PLANE_FIELD_BITS];
        nz = plane[2*PLANE_FIELD_BITS +: PLANE_FIELD_BITS];
        d  = plane[3*PLANE_FIELD_BITS +: PLANE_FIELD_BITS];
        return longint'(nx) * x + longint'(ny) * y + longint'(nz) * z
               + longint'(d) * (longint'(1) << NORMAL_FRAC_BITS);
    endfunction

    // A box survives only if every plane has at least one corner strictly in front of it.
    function automatic logic corners_in_view(input longint lo_x, input longint lo_y,
                                             input longint lo_z, input longint hi_x,
                                             input longint hi_y, input longint hi_z);
        logic   any_front;
        longint cx;
        longint cy;
        longint cz;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            any_front = 1'b0;
            for (int c = 0; c < 8; c++)
            begin
                cx = c[2] ? hi_x : lo_x;
                cy = c[1] ? hi_y : lo_y;
                cz = c[0] ? hi_z : lo_z;
                if (plane_distance(plane_regs[p], cx, cy, cz) > 0)
                    any_front = 1'b1;
            end
            if (!any_front)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic predict_visible(input op_t op, input logic [S_TDATA_BITS-1:0] data);
        longint x0;
        longint y0;
        longint z0;
        longint ext;
        longint dist_value;
        logic   seen;
        x0   = coord_at(data, 0);
        y0   = coord_at(data, 1);
        z0   = coord_at(data, 2);
        ext  = longint'(data[6*COORD_BITS +: EXTENT_BITS]);
        seen = 1'b1;
        case (op)
            OP_POINT:
            begin
                for (int p = 0; p < NUM_PLANES; p++)
                begin
                    dist_value = plane_distance(plane_regs[p], x0, y0, z0);
                    if (dist_value <= 0)
                        seen = 1'b0;
                end
            end
            OP_SPHERE:
            begin
                for (int p = 0; p < NUM_PLANES; p++)
                begin
                    dist_value = plane_distance(plane_regs[p], x0, y0, z0);
                    if (dist_value <= -(ext * (longint'(1) << NORMAL_FRAC_BITS)))
                        seen = 1'b0;
                end
            end
            OP_BOX:
                seen = corners_in_view(x0, y0, z0, coord_at(data, 3), coord_at(data, 4),
                                       coord_at(data, 5));
            default:
                seen = corners_in_view(x0, y0, z0, x0 + ext, y0 + ext, z0 + ext);
        endcase
        return seen;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        cull_verdict_t head;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
                plane_regs[i] = '0;
            verdict_q.delete();
            pending_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (verdict_q.size() == 0)
                    report_mismatch($sformatf("result visible=%0b with no request waiting",
                                              m_tdata[0]));
                else
                begin
                    head = verdict_q.pop_front();
                    if (m_tdata[0] !== head.visible)
                        report_mismatch($sformatf("request %0d (%s): visible=%0b, wanted %0b",
                                                  head.tag, head.op.name(), m_tdata[0],
                                                  head.visible));
                    if (head.visible)
                        visible_count++;
                end
            end
            if (cfg_valid && cfg_ready && cfg_index < NUM_PLANES)
                plane_regs[cfg_index] = cfg_data;
            if (s_tvalid && s_tready)
            begin
                head.op      = op_t'(s_tuser);
                head.visible = predict_visible(head.op, s_tdata);
                head.tag     = query_count;
                query_count++;
                verdict_q.push_back(head);
            end
            pending_count = verdict_q.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
// Top of the frustum volume cull testbench: clock, reset, plane settings and query stimulus.
module testbench;
    import fvc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_PERCENT = 37;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [S_TDATA_BITS-1:0]   s_tdata;
    logic [S_TUSER_BITS-1:0]   s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [M_TDATA_BITS-1:0]   m_tdata;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [PLANE_BITS-1:0]     cfg_data;

    logic                      steady;
    logic [PLANE_BITS-1:0]     plane_set [NUM_PLANES];
    int                        cycle_count;
    int                        settings_count;
    int                        fail_count;
    int                        pending_count;
    int                        result_count;
    int                        visible_count;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    frustum_volume_cull dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fvc_checker cull_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count),
        .visible_count (visible_count)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);

    function automatic logic [PLANE_BITS-1:0] make_plane(input int nx, input int ny,
                                                         input int nz, input int d);
        return {d[15:0], nz[15:0], ny[15:0], nx[15:0]};
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_coord();
        int v;
        case ($urandom_range(3))
            0: v = int'($urandom);
            1: v = int'($urandom_range(20000)) - 10000;
            2:
            begin
                case ($urandom_range(3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = ($urandom_range(1) ? 8000 : -8000) + int'($urandom_range(128)) - 64;
        endcase
        return COORD_BITS'(v);
    endfunction

    function automatic extent_t pick_extent();
        case ($urandom_range(3))
            0: return extent_t'($urandom);
            1: return extent_t'($urandom_range(1));
            2: return '1;
            default: return extent_t'($urandom_range(2000));
        endcase
    endfunction

    task automatic send_query(input op_t op, input logic [COORD_BITS-1:0] x0,
                              input logic [COORD_BITS-1:0] y0, input logic [COORD_BITS-1:0] z0,
                              input logic [COORD_BITS-1:0] x1, input logic [COORD_BITS-1:0] y1,
                              input logic [COORD_BITS-1:0] z1, input extent_t ext);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_BITS'({ext, z1, y1, x1, z0, y0, x0});
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        op_t                   op;
        logic [COORD_BITS-1:0] a [6];
        logic [COORD_BITS-1:0] t;
        for (int n = 0; n < count; n++)
        begin
            op = op_t'($urandom_range(3));
            foreach (a[k])
                a[k] = pick_coord();
            if (op == OP_BOX && $urandom_range(9) < 8)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if ($signed(a[k]) > $signed(a[k+3]))
                    begin
                        t      = a[k];
                        a[k]   = a[k+3];
                        a[k+3] = t;
                    end
                end
            end
            send_query(op, a[0], a[1], a[2], a[3], a[4], a[5], pick_extent());
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [PLANE_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // Writes to the unused indexes are mixed in; the block must ignore them.
    task automatic load_planes();
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            if ($urandom_range(3) == 0)
                write_reg(CFG_INDEX_BITS'(NUM_PLANES + $urandom_range(1)), {$urandom, $urandom});
            write_reg(CFG_INDEX_BITS'(i), plane_set[i]);
        end
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_POINT;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        steady    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // All planes are zero after reset.
        settings_count = 1;
        send_query(OP_POINT, 0, 0, 0, 0, 0, 0, 0);
        send_query(OP_SPHERE, 100, -100, 5, 0, 0, 0, 0);
        send_query(OP_SPHERE, 100, -100, 5, 0, 0, 0, 1);
        send_query(OP_BOX, -100, -100, -100, 100, 100, 100, 0);
        send_query(OP_CUBE, -50, -50, -50, 0, 0, 0, 50);
        send_random(40);

        // Axis-aligned frustum with walls at plus and minus 8000.
        drain();
        plane_set[0] = make_plane(16384, 0, 0, 8000);
        plane_set[1] = make_plane(-16384, 0, 0, 8000);
        plane_set[2] = make_plane(0, -16384, 0, 8000);
        plane_set[3] = make_plane(0, 16384, 0, 8000);
        plane_set[4] = make_plane(0, 0, 16384, 8000);
        plane_set[5] = make_plane(0, 0, -16384, 8000);
        load_planes();
        send_query(OP_POINT, 0, 0, 0, 0, 0, 0, 0);
        send_query(OP_POINT, -8000, 0, 0, 0, 0, 0, 0);
        send_query(OP_POINT, -7999, 0, 0, 0, 0, 0, 0);
        send_query(OP_POINT, -32768, 32767, 0, 0, 0, 0, 0);
        send_query(OP_POINT, 10, 20, 30, -32768, 32767, -32768, 32767);
        send_query(OP_SPHERE, -9000, 0, 0, 0, 0, 0, 1000);
        send_query(OP_SPHERE, -9000, 0, 0, 0, 0, 0, 1001);
        send_query(OP_SPHERE, 32767, 32767, -32768, 0, 0, 0, 32767);
        send_query(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0);
        send_query(OP_BOX, -100, -100, -100, 100, 100, 100, 0);
        send_query(OP_BOX, 9000, 0, 0, 10000, 10, 10, 0);
        send_query(OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
        send_query(OP_BOX, 100, 100, 100, -100, -100, -100, 0);
        send_query(OP_BOX, 10000, 0, 0, 9000, 0, 0, 0);
        send_query(OP_BOX, 32767, 32767, 32767, 32767, 32767, 32767, 0);
        send_query(OP_CUBE, -8000, -8000, -8000, 0, 0, 0, 0);
        send_query(OP_CUBE, -8001, -8001, -8001, 0, 0, 0, 1);
        send_query(OP_CUBE, -8001, -8001, -8001, 0, 0, 0, 2);
        send_query(OP_CUBE, 32000, 0, 0, 0, 0, 0, 32767);
        send_query(OP_CUBE, -32768, -32768, -32768, 0, 0, 0, 32767);
        send_random(120);

        // Perspective frustum looking down +z, with the receiver never stalling.
        drain();
        plane_set[0] = make_plane(11585, 0, 11585, 0);
        plane_set[1] = make_plane(-11585, 0, 11585, 0);
        plane_set[2] = make_plane(0, -11585, 11585, 0);
        plane_set[3] = make_plane(0, 11585, 11585, 0);
        plane_set[4] = make_plane(0, 0, 16384, -100);
        plane_set[5] = make_plane(0, 0, -16384, 20000);
        load_planes();
        steady = 1'b1;
        send_random(120);
        steady = 1'b0;

        // Largest and smallest plane fields.
        drain();
        plane_set[0] = make_plane(32767, 32767, 32767, 32767);
        plane_set[1] = make_plane(-32768, -32768, -32768, -32768);
        plane_set[2] = make_plane(32767, -32768, 32767, 32767);
        plane_set[3] = make_plane(-32768, 32767, -32768, 32767);
        plane_set[4] = make_plane(0, 0, 32767, -32768);
        plane_set[5] = make_plane(-32768, 0, 0, 32767);
        load_planes();
        send_random(60);

        drain();
        foreach (plane_set[i])
            plane_set[i] = '1;
        load_planes();
        send_random(40);

        // Random planes; every other setting keeps the offsets large and positive.
        for (int r = 0; r < 4; r++)
        begin
            drain();
            foreach (plane_set[i])
            begin
                plane_set[i] = {$urandom, $urandom};
                if (r[0])
                    plane_set[i][PLANE_BITS-1 -: 2] = 2'b01;
            end
            load_planes();
            send_random(60);
        end

        drain();
        foreach (plane_set[i])
            plane_set[i] = '0;
        load_planes();
        send_random(20);

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Checked %0d cull results over %0d plane settings, %0d of them visible.",
                 result_count, settings_count, visible_count);
        $display("Queries mixed points, spheres, boxes and cubes with random stalls on both sides.");
        if (fail_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
